/* rtl/nwti_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nwti_pkg
// Shared types and constants for the number-to-word token generator.
// ----------------------------------------------------------------------------
package nwti_pkg;

    localparam int VALUE_W  = 32;
    localparam int TOKEN_W  = 6;
    localparam int DIGITS   = 9;
    localparam int BCD_W    = 4 * DIGITS;
    localparam int CONV_W   = 30;   // 999999999 fits in 30 bits
    localparam int BITS_PER = 5;    // bits folded into the BCD word per cycle
    localparam int SLOTS    = 13;

    localparam logic [2:0] STEPS = 3'(CONV_W / BITS_PER);

    localparam logic [VALUE_W-1:0] RANGE_MAX = 32'd999_999_999;

    localparam logic [TOKEN_W-1:0] TOK_ZERO     = 6'd0;
    localparam logic [TOKEN_W-1:0] TOK_TEN      = 6'd10;
    localparam logic [TOKEN_W-1:0] TOK_TWENTY   = 6'd20;
    localparam logic [TOKEN_W-1:0] TOK_CRORE    = 6'd28;
    localparam logic [TOKEN_W-1:0] TOK_LAKH     = 6'd29;
    localparam logic [TOKEN_W-1:0] TOK_THOUSAND = 6'd30;
    localparam logic [TOKEN_W-1:0] TOK_HUNDRED  = 6'd31;
    localparam logic [TOKEN_W-1:0] TOK_RANGE    = 6'd32;

    // Classified number handed from the front to the back.
    typedef struct packed {
        logic             oor;
        logic             zero;
        logic [BCD_W-1:0] bcd;   // digit 0 in the lowest nibble
    } entry_t;

endpackage

/* rtl/nwti_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nwti_front
// Accepts numbers, classifies them and converts in-range values to BCD.
// ----------------------------------------------------------------------------
module nwti_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [31:0]      s_tdata,
    output logic             push_valid,
    input  logic             push_ready,
    output nwti_pkg::entry_t push_data
);
    import nwti_pkg::*;

    logic                busy_reg, busy_next;
    logic [2:0]          cnt_reg, cnt_next;
    logic [CONV_W-1:0]   bits_reg, bits_next;
    logic [BCD_W-1:0]    bcd_reg, bcd_next;
    logic                oor_reg, oor_next;
    logic                zero_reg, zero_next;
    logic                s_fire;
    logic                push_fire;
    logic                bcd_ok;

    // Shift-add-3 over BITS_PER input bits, MSB first.
    function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] bcd_in,
                                                 input logic [BITS_PER-1:0] bits);
        logic [BCD_W-1:0] b;
        b = bcd_in;
        for (int i = BITS_PER - 1; i >= 0; i--)
        begin
            for (int d = 0; d < DIGITS; d++)
            begin
                if (b[4*d +: 4] >= 4'd5)
                    b[4*d +: 4] = b[4*d +: 4] + 4'd3;
            end
            b = {b[BCD_W-2:0], bits[i]};
        end
        return b;
    endfunction

    assign push_valid = busy_reg && (cnt_reg == STEPS);
    assign push_fire  = push_valid && push_ready;
    assign s_tready   = !busy_reg || push_fire;
    assign s_fire     = s_tvalid && s_tready;

    assign push_data.oor  = oor_reg;
    assign push_data.zero = zero_reg;
    assign push_data.bcd  = bcd_reg;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        bits_next = bits_reg;
        bcd_next  = bcd_reg;
        oor_next  = oor_reg;
        zero_next = zero_reg;
        if (push_fire)
            busy_next = 1'b0;
        if (busy_reg && (cnt_reg != STEPS))
        begin
            cnt_next  = cnt_reg + 3'd1;
            bcd_next  = dabble(bcd_reg, bits_reg[CONV_W-1 -: BITS_PER]);
            bits_next = {bits_reg[CONV_W-BITS_PER-1:0], {BITS_PER{1'b0}}};
        end
        if (s_fire)
        begin
            busy_next = 1'b1;
            oor_next  = s_tdata > RANGE_MAX;
            zero_next = s_tdata == '0;
            bits_next = s_tdata[CONV_W-1:0];
            bcd_next  = '0;
            // out-of-range numbers need no conversion
            cnt_next  = (s_tdata > RANGE_MAX) ? STEPS : 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
        bcd_reg  <= bcd_next;
        oor_reg  <= oor_next;
        zero_reg <= zero_next;
    end

    always_comb
    begin
        bcd_ok = 1'b1;
        for (int d = 0; d < DIGITS; d++)
        begin
            if (bcd_reg[4*d +: 4] > 4'd9)
                bcd_ok = 1'b0;
        end
    end

    a_conv_holds: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && (cnt_reg != STEPS) |=> busy_reg && (cnt_reg == $past(cnt_reg) + 3'd1))
        else $error("conversion abandoned or skipped a step");

    a_bcd_digits: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid && !oor_reg |-> bcd_ok)
        else $error("BCD digit out of range at push");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= STEPS)
        else $error("step counter overran");

endmodule

/* rtl/nwti_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nwti_queue
// Two-entry queue of classified numbers between front and back.
// ----------------------------------------------------------------------------
module nwti_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  nwti_pkg::entry_t push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output nwti_pkg::entry_t pop_data
);
    import nwti_pkg::*;

    entry_t     entries [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push_fire;
    logic       pop_fire;

    assign push_ready = count_reg != 2'd2;
    assign pop_valid  = count_reg != 2'd0;
    assign pop_data   = entries[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push_fire;
        rd_ptr_next = rd_ptr_reg ^ pop_fire;
        count_next  = count_reg + {1'b0, push_fire} - {1'b0, pop_fire};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
            entries[wr_ptr_reg] <= push_data;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("queue count overflow");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 2'd1 |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

/* rtl/nwti_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nwti_back
// Expands one classified number into its token slots and emits one token
// per cycle through an output register, unless m_tready holds it off.
// ----------------------------------------------------------------------------
module nwti_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  nwti_pkg::entry_t pop_data,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tlast
);
    import nwti_pkg::*;

    typedef struct packed {
        logic [2:0]              valid;
        logic [2:0][TOKEN_W-1:0] tok;   // word, units word, group word
    } pair_t;

    typedef struct packed {
        logic [SLOTS-1:0]              mask;
        logic [SLOTS-1:0][TOKEN_W-1:0] tok;
    } slots_t;

    function automatic pair_t pair_words(input logic [3:0] t, input logic [3:0] u,
                                         input logic [TOKEN_W-1:0] group_tok);
        pair_t p;
        p.valid  = '0;
        p.tok[0] = TOK_TWENTY + {2'b00, t} - 6'd2;
        p.tok[1] = {2'b00, u};
        p.tok[2] = group_tok;
        if (t == 4'd0)
            p.valid[1] = u != 4'd0;
        else if (t == 4'd1)
        begin
            p.valid[0] = 1'b1;
            p.tok[0]   = TOK_TEN + {2'b00, u};
        end
        else
        begin
            p.valid[0] = 1'b1;
            p.valid[1] = u != 4'd0;
        end
        p.valid[2] = (t != 4'd0) || (u != 4'd0);
        return p;
    endfunction

    // Slot layout: crore 0-2, lakh 3-5, thousand 6-8, hundred 9-10, rest 11-12.
    function automatic slots_t build(input entry_t e);
        slots_t s;
        pair_t  p;
        logic [DIGITS-1:0][3:0] d;
        d = e.bcd;
        s.mask = '0;
        s.tok  = '0;
        if (e.oor)
        begin
            s.mask[0] = 1'b1;
            s.tok[0]  = TOK_RANGE;
        end
        else if (e.zero)
        begin
            s.mask[0] = 1'b1;
            s.tok[0]  = TOK_ZERO;
        end
        else
        begin
            p = pair_words(d[8], d[7], TOK_CRORE);
            s.mask[2:0] = p.valid;
            s.tok[2:0]  = p.tok;
            p = pair_words(d[6], d[5], TOK_LAKH);
            s.mask[5:3] = p.valid;
            s.tok[5:3]  = p.tok;
            p = pair_words(d[4], d[3], TOK_THOUSAND);
            s.mask[8:6] = p.valid;
            s.tok[8:6]  = p.tok;
            s.mask[9]   = d[2] != 4'd0;
            s.mask[10]  = d[2] != 4'd0;
            s.tok[9]    = {2'b00, d[2]};
            s.tok[10]   = TOK_HUNDRED;
            p = pair_words(d[1], d[0], TOK_HUNDRED);
            s.mask[12:11] = p.valid[1:0];
            s.tok[12:11]  = p.tok[1:0];
        end
        return s;
    endfunction

    logic [SLOTS-1:0]              mask_reg, mask_next;
    logic [SLOTS-1:0][TOKEN_W-1:0] slot_tok_reg, slot_tok_next;
    logic                          out_valid_reg, out_valid_next;
    logic [TOKEN_W-1:0]            out_tok_reg, out_tok_next;
    logic                          out_last_reg, out_last_next;
    logic [SLOTS-1:0]              sel;
    logic [SLOTS-1:0]              rem;
    logic [SLOTS-1:0]              mask_after;
    logic [TOKEN_W-1:0]            tok_sel;
    logic                          adv;
    logic                          load;
    slots_t                        built;

    assign built = build(pop_data);
    assign adv   = (mask_reg != '0) && (!out_valid_reg || m_tready);
    assign sel   = mask_reg & (~mask_reg + 13'd1);   // lowest pending slot
    assign rem   = mask_reg & ~sel;

    always_comb
    begin
        tok_sel = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (sel[i])
                tok_sel = tok_sel | slot_tok_reg[i];
        end
    end

    assign mask_after = adv ? rem : mask_reg;
    assign load       = (mask_after == '0) && pop_valid;
    assign pop_ready  = load;

    always_comb
    begin
        mask_next      = load ? built.mask : mask_after;
        slot_tok_next  = load ? built.tok : slot_tok_reg;
        out_valid_next = out_valid_reg;
        out_tok_next   = out_tok_reg;
        out_last_next  = out_last_reg;
        if (adv)
        begin
            out_valid_next = 1'b1;
            out_tok_next   = tok_sel;
            out_last_next  = rem == '0;
        end
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_tok_reg <= slot_tok_next;
        out_tok_reg  <= out_tok_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_tok_reg};
    assign m_tlast  = out_last_reg;

    a_load_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> mask_reg != '0)
        else $error("loaded number produced no tokens");

    a_load_only_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (mask_reg == '0) || (adv && (rem == '0)))
        else $error("new number loaded over pending tokens");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        adv && (rem != '0) |=> !out_last_reg)
        else $error("last flag set with tokens still pending");

endmodule

/* rtl/number_to_word_tokens_indian.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// number_to_word_tokens_indian
// Spoken-word token generator for unsigned numbers, Indian grouping.
// ----------------------------------------------------------------------------
//  channel   dir  fields (tdata low bit up)             tlast
//  s_*       in   value[31:0]                            -
//  m_*       out  token[5:0], 2'b0 pad                   last token of number
//
//  The front takes a number, then runs a 5-bit-per-step binary-to-BCD
//  conversion; out-of-range numbers skip it. It takes no new number until it
//  hands the last one on. The back emits 1 to 13 tokens per number at one
//  per cycle while the output is not stalled.
//  A two-entry queue lets the front convert ahead while the output stalls.
//  Reset empties the queue and output register; no clearing pass is needed.
// ----------------------------------------------------------------------------
module number_to_word_tokens_indian (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // value[31:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // token[5:0], zero pad [7:6]
    output logic        m_tlast
);
    import nwti_pkg::*;

    logic   f_valid, f_ready;
    entry_t f_data;
    logic   b_valid, b_ready;
    entry_t b_data;

    nwti_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_data)
    );

    nwti_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_data),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_data)
    );

    nwti_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (b_valid),
        .pop_ready (b_ready),
        .pop_data  (b_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
